// ----- rtl/fpa_pkg.sv -----
`timescale 1ns / 1ps
package fpa_pkg;

    localparam int unsigned WORD_W = 32;

    typedef enum logic [3:0] {
        MODE_ADD      = 4'd0,
        MODE_SUB      = 4'd1,
        MODE_MUL      = 4'd2,
        MODE_DIV      = 4'd3,
        MODE_GT       = 4'd4,
        MODE_LT       = 4'd5,
        MODE_GE       = 4'd6,
        MODE_LE       = 4'd7,
        MODE_EQ       = 4'd8,
        MODE_NE       = 4'd9,
        MODE_MIN      = 4'd10,
        MODE_MAX      = 4'd11,
        MODE_INC      = 4'd12,
        MODE_DEC      = 4'd13,
        MODE_FROM_INT = 4'd14,
        MODE_TO_INT   = 4'd15
    } t_mode;

    // Classified operation as held in the front-to-back queue
    typedef struct packed {
        t_mode                     mode;
        logic signed [WORD_W-1:0]  a;
        logic signed [WORD_W-1:0]  b;
        logic [WORD_W-1:0]         mag_a;
        logic [WORD_W-1:0]         mag_b;
        logic                      neg;
        logic                      dz;
    } t_op;

    typedef struct packed {
        logic signed [WORD_W-1:0]  value;
        logic                      cmp;
        logic                      dz;
    } t_res;

endpackage

// ----- rtl/fixed_point_alu.sv -----
`timescale 1ns / 1ps
// Signed fixed-point ALU, FRAC_BITS fraction bits, 32-bit raw operands.
// Input side is a queue: drive mode/operands, raise push; the item is
// taken on an edge with push high and full low.
// Result side is a queue too: while empty is low the oldest result sits on
// o_result_value / o_compare_true / o_divide_by_zero; pop takes it.
// Every item, whatever its mode, runs through one in-order pipeline:
// the front splits sign and magnitude, a 4-entry queue decouples it from
// the back, whose pipeline is FRAC_BITS+34 stages long (entry, multiply
// shift, one restoring-divide stage per quotient bit), then a 2-entry
// result queue.
// Throughput: one item per cycle for all modes mixed, while the result queue is not full.
// The depth is set by the divider: one quotient bit per stage.
// Reset clears queue pointers and counts and pipeline valid bits only;
// queue storage and pipeline data are not reset.
// When the receiver stalls the result queue fills, the back pipeline
// freezes, the input queue fills and full rises. Nothing is dropped.
module fixed_point_alu #(
    parameter int FRAC_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [3:0]          i_mode,
    input  logic signed [31:0]  i_operand_a,
    input  logic signed [31:0]  i_operand_b,
    output logic                empty,
    input  logic                pop,
    output logic signed [31:0]  o_result_value,
    output logic                o_compare_true,
    output logic                o_divide_by_zero
);
    import fpa_pkg::*;

    t_op  front_op, queue_op;
    t_res back_res, out_res;
    logic op_empty, op_pop, res_push, res_full;

    // classify: sign/magnitude and divide-by-zero flag
    fpa_front u_front (
        .i_mode      (i_mode),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_op        (front_op)
    );

    // decoupling queue between front and back
    fpa_queue #(.T(t_op), .DEPTH(4)) u_op_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_op),
        .o_full  (full),
        .i_pop   (op_pop),
        .o_data  (queue_op),
        .o_empty (op_empty)
    );

    // execution pipeline
    fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (queue_op),
        .i_op_empty (op_empty),
        .o_op_pop   (op_pop),
        .o_res      (back_res),
        .o_res_push (res_push),
        .i_res_full (res_full)
    );

    // result queue, parts the pipeline from the receiver
    fpa_queue #(.T(t_res), .DEPTH(2)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (out_res),
        .o_empty (empty)
    );

    assign o_result_value   = out_res.value;
    assign o_compare_true   = out_res.cmp;
    assign o_divide_by_zero = out_res.dz;
endmodule

// ----- rtl/fpa_queue.sv -----
`timescale 1ns / 1ps
module fpa_queue #(
    parameter type T     = logic,
    parameter int  DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    T               r_mem [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_cnt;
    logic           wr, rd;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == LAST) ? '0 : r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= (r_rp == LAST) ? '0 : r_rp + 1'b1;
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

// ----- rtl/fpa_front.sv -----
`timescale 1ns / 1ps
module fpa_front (
    input  logic [3:0]          i_mode,
    input  logic signed [31:0]  i_operand_a,
    input  logic signed [31:0]  i_operand_b,
    output fpa_pkg::t_op        o_op
);
    import fpa_pkg::*;

    // Sign/magnitude split for the divider; magnitude of the most
    // negative value is 2^31, which still fits unsigned.
    always_comb begin
        o_op.mode  = t_mode'(i_mode);
        o_op.a     = i_operand_a;
        o_op.b     = i_operand_b;
        o_op.mag_a = i_operand_a[31] ? (32'd0 - i_operand_a) : i_operand_a;
        o_op.mag_b = i_operand_b[31] ? (32'd0 - i_operand_b) : i_operand_b;
        o_op.neg   = i_operand_a[31] ^ i_operand_b[31];
        o_op.dz    = (i_operand_b == '0);
    end
endmodule

// ----- rtl/fpa_back.sv -----
`timescale 1ns / 1ps
module fpa_back #(
    parameter int FRAC_BITS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  fpa_pkg::t_op  i_op,
    input  logic          i_op_empty,
    output logic          o_op_pop,
    output fpa_pkg::t_res o_res,
    output logic          o_res_push,
    input  logic          i_res_full
);
    import fpa_pkg::*;

    localparam int QW   = WORD_W + FRAC_BITS;  // quotient / dividend width
    localparam int NDIV = QW;                  // one quotient bit per stage
    localparam int NS   = NDIV + 2;            // + entry stage + multiply shift

    typedef struct packed {
        logic               is_div;
        logic               is_mul;
        logic               neg;
        logic               dz;
        logic               cmp;
        logic [WORD_W-1:0]  res;
        logic [WORD_W:0]    rem;
        logic [QW-1:0]      dq;
        logic [WORD_W-1:0]  mb;
    } t_stg;

    t_stg                   r_stg [NS];
    t_stg                   n_stg [NS];
    logic [NS-1:0]          r_vld;
    logic signed [63:0]     r_prod;
    logic signed [63:0]     prod_sh;
    logic                   en;
    logic                   lt_ab, lt_ba;

    // Whole pipeline moves together; stalls only when the result queue is full
    assign en       = !i_res_full;
    assign o_op_pop = en && !i_op_empty;

    assign lt_ab   = (i_op.a < i_op.b);
    assign lt_ba   = (i_op.b < i_op.a);
    assign prod_sh = r_prod >>> FRAC_BITS;

    always_comb begin
        logic [WORD_W:0] t;
        t = '0;
        // entry stage
        n_stg[0]        = '0;
        n_stg[0].is_div = (i_op.mode == MODE_DIV);
        n_stg[0].is_mul = (i_op.mode == MODE_MUL);
        n_stg[0].neg    = i_op.neg;
        n_stg[0].dz     = i_op.dz && (i_op.mode == MODE_DIV);
        n_stg[0].dq     = {i_op.mag_a, {FRAC_BITS{1'b0}}};
        n_stg[0].mb     = i_op.mag_b;
        case (i_op.mode)
            MODE_ADD:      n_stg[0].res = i_op.a + i_op.b;
            MODE_SUB:      n_stg[0].res = i_op.a - i_op.b;
            MODE_GT:       n_stg[0].cmp = lt_ba;
            MODE_LT:       n_stg[0].cmp = lt_ab;
            MODE_GE:       n_stg[0].cmp = !lt_ab;
            MODE_LE:       n_stg[0].cmp = !lt_ba;
            MODE_EQ:       n_stg[0].cmp = (i_op.a == i_op.b);
            MODE_NE:       n_stg[0].cmp = (i_op.a != i_op.b);
            MODE_MIN:      n_stg[0].res = lt_ab ? i_op.a : i_op.b;
            MODE_MAX:      n_stg[0].res = lt_ba ? i_op.a : i_op.b;
            MODE_INC:      n_stg[0].res = i_op.a + 32'sd1;
            MODE_DEC:      n_stg[0].res = i_op.a - 32'sd1;
            MODE_FROM_INT: n_stg[0].res = i_op.a << FRAC_BITS;
            MODE_TO_INT:   n_stg[0].res = i_op.a >>> FRAC_BITS;
            default:       n_stg[0].res = '0;
        endcase
        // multiply shift stage
        n_stg[1] = r_stg[0];
        if (r_stg[0].is_mul) begin
            n_stg[1].res = prod_sh[WORD_W-1:0];
        end
        n_stg[1].rem = '0;
        // restoring divide, one quotient bit per stage
        for (int k = 2; k < NS; k++) begin
            n_stg[k] = r_stg[k-1];
            t = {r_stg[k-1].rem[WORD_W-1:0], r_stg[k-1].dq[QW-1]};
            if (t >= {1'b0, r_stg[k-1].mb}) begin
                n_stg[k].rem = t - {1'b0, r_stg[k-1].mb};
                n_stg[k].dq  = {r_stg[k-1].dq[QW-2:0], 1'b1};
            end else begin
                n_stg[k].rem = t;
                n_stg[k].dq  = {r_stg[k-1].dq[QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NS; k++) begin
                r_stg[k] <= n_stg[k];
            end
            r_prod <= i_op.a * i_op.b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NS-2:0], !i_op_empty};
        end
    end

    // Final select and sign fix of the quotient
    always_comb begin
        o_res.cmp = r_stg[NS-1].cmp;
        o_res.dz  = r_stg[NS-1].dz;
        if (!r_stg[NS-1].is_div) begin
            o_res.value = r_stg[NS-1].res;
        end else if (r_stg[NS-1].dz) begin
            o_res.value = '0;
        end else if (r_stg[NS-1].neg) begin
            o_res.value = 32'd0 - r_stg[NS-1].dq[WORD_W-1:0];
        end else begin
            o_res.value = r_stg[NS-1].dq[WORD_W-1:0];
        end
    end

    assign o_res_push = en && r_vld[NS-1];
endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
module tb;
    import fpa_pkg::*;

    localparam int FRAC   = 8;
    localparam int LAT    = FRAC + 35;   // push to result visible
    localparam int LIMIT  = 2000000;

    // Everything the block sees is driven from the first instant
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               pop = 1'b0;
    logic [3:0]         i_mode = MODE_ADD;
    logic signed [31:0] i_operand_a = '0;
    logic signed [31:0] i_operand_b = '0;
    logic               full, empty;
    logic signed [31:0] o_result_value;
    logic               o_compare_true, o_divide_by_zero;

    // Expected results, oldest first: value, compare flag, div-by-zero flag
    typedef struct packed {
        logic [31:0] value;
        logic        cmp;
        logic        dz;
    } t_alu_out;

    t_alu_out    alu_expected[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    fixed_point_alu #(.FRAC_BITS(FRAC)) u_dut (
        .i_clk, .i_rst_n, .push, .full, .i_mode, .i_operand_a, .i_operand_b,
        .empty, .pop, .o_result_value, .o_compare_true, .o_divide_by_zero
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a stuck handshake must not hang the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Predicts the ALU's output for one item, in the block's own widths
    function automatic t_alu_out alu_compute(t_mode m, logic signed [31:0] a,
                                             logic signed [31:0] b);
        t_alu_out        r;
        logic signed [63:0] prod;
        logic [63:0]     mag_a, mag_b, quo;
        r = '0;
        case (m)
            MODE_ADD:  r.value = a + b;
            MODE_SUB:  r.value = a - b;
            MODE_MUL: begin
                prod = 64'(a) * 64'(b);
                r.value = 32'(prod >>> FRAC);
            end
            MODE_DIV: begin
                if (b == 0) begin
                    r.dz = 1'b1;
                end else begin
                    // widen before the shift so the dividend cannot overflow
                    mag_a = a[31] ? -64'(a) : 64'(a);
                    mag_b = b[31] ? -64'(b) : 64'(b);
                    quo = (mag_a << FRAC) / mag_b;
                    r.value = (a[31] != b[31]) ? 32'(-quo) : 32'(quo);
                end
            end
            MODE_GT:   r.cmp = a > b;
            MODE_LT:   r.cmp = a < b;
            MODE_GE:   r.cmp = a >= b;
            MODE_LE:   r.cmp = a <= b;
            MODE_EQ:   r.cmp = a == b;
            MODE_NE:   r.cmp = a != b;
            MODE_MIN:  r.value = (a < b) ? a : b;    // tie gives b
            MODE_MAX:  r.value = (b < a) ? a : b;    // tie gives b
            MODE_INC:  r.value = a + 1;
            MODE_DEC:  r.value = a - 1;
            MODE_FROM_INT: r.value = a << FRAC;
            default:   r.value = a >>> FRAC;
        endcase
        return r;
    endfunction

    // Result side: pop changes on the falling edge, acceptance sampled on rising
    always @(negedge i_clk) begin
        pop <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_alu_out exp_out;
        if (i_rst_n && pop && !empty) begin
            if (alu_expected.size() == 0) begin
                $error("result with no item outstanding: value %h", o_result_value);
                fail_count++;
            end else begin
                exp_out = alu_expected.pop_front();
                if (o_result_value !== exp_out.value) begin
                    $error("result_value: expected %h, got %h", exp_out.value,
                           o_result_value);
                    fail_count++;
                end
                if (o_compare_true !== exp_out.cmp) begin
                    $error("compare_true: expected %b, got %b", exp_out.cmp,
                           o_compare_true);
                    fail_count++;
                end
                if (o_divide_by_zero !== exp_out.dz) begin
                    $error("divide_by_zero: expected %b, got %b", exp_out.dz,
                           o_divide_by_zero);
                    fail_count++;
                end
            end
        end
    end

    // Sends one item: optional random gap, then hold push until it is taken.
    // Push is left high on return; the next item or a pause lowers it.
    task automatic send_item(t_mode m, logic [31:0] a, logic [31:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push        <= 1'b1;
        i_mode      <= m;
        i_operand_a <= a;
        i_operand_b <= b;
        do @(posedge i_clk); while (full);
        alu_expected.push_back(alu_compute(m, a, b));
        @(negedge i_clk);
    endtask

    // Random operand biased towards the interesting corners
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($urandom_range(3)) - 32'd1;
            3: return 32'($signed(16'($urandom())));
            4: return {$urandom_range(1) ? 24'hFFFFFF : 24'h0, 8'($urandom())};
            default: return $urandom();
        endcase
    endfunction

    task automatic wait_drained();
        push <= 1'b0;
        while (alu_expected.size() != 0) @(negedge i_clk);
    endtask

    // Extremes, every mode, zero divisor, min/max ties, wrap cases
    task automatic test_directed();
        t_mode m;
        m = MODE_ADD;
        do begin
            send_item(m, 32'h8000_0000, 32'h7FFF_FFFF);
            m = m.next();
        end while (m != MODE_ADD);
        send_item(MODE_DIV, 32'h0000_0100, 32'h0);
        send_item(MODE_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        send_item(MODE_DIV, 32'hFFFF_FF00, 32'h0000_0300);
        send_item(MODE_MUL, 32'hFFFF_FFFF, 32'h0000_0001);
        send_item(MODE_MIN, 32'h0000_1234, 32'h0000_1234);
        send_item(MODE_MAX, 32'hFFFF_0000, 32'hFFFF_0000);
        send_item(MODE_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
        send_item(MODE_INC, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(MODE_DEC, 32'h8000_0000, 32'h0);
        send_item(MODE_EQ,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) begin
            send_item(t_mode'($urandom_range(15)), pick_operand(), pick_operand());
        end
    endtask

    // Sender holds off until the pipeline has fully drained, then bursts
    task automatic test_drain_pause();
        wait_drained();
        test_random(100);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        send_idle_pct = 10; recv_idle_pct = 60;
        test_random(650);
        test_drain_pause();
        send_idle_pct = 60; recv_idle_pct = 10;
        test_random(600);
        send_idle_pct = 0;  recv_idle_pct = 0;
        test_random(650);

        wait_drained();
        repeat (LAT) @(negedge i_clk);
        if (fail_count == 0 && alu_expected.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// ----- fixed_point_alu.f -----
rtl/fpa_pkg.sv
rtl/fpa_queue.sv
rtl/fpa_front.sv
rtl/fpa_back.sv
rtl/fixed_point_alu.sv
test/tb.sv
